FILE: hw/rtl/sct_pkg.sv
package sct_pkg;

    localparam int VALUE_W      = 32;
    localparam int IDX_PORT_W   = 16;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_PORT_W = 9;
    localparam int DIM_W        = 17;
    localparam int CFG_IDX_W    = 8;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_INDEX_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SET       = 3'd0,
        MODE_GET       = 3'd1,
        MODE_ADD       = 3'd2,
        MODE_REMOVE    = 3'd3,
        MODE_SCALE     = 3'd4,
        MODE_TRANSPOSE = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/sct_mem.sv
module sct_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sct_ctrl.sv
module sct_ctrl #(
    parameter int CAPACITY   = 256,
    parameter int INDEX_BITS = 16,
    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int ENTRY_W = 2 * INDEX_BITS + sct_pkg::VALUE_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sct_pkg::MODE_W-1:0]        s_mode,
    input  logic [sct_pkg::IDX_PORT_W-1:0]    s_row,
    input  logic [sct_pkg::IDX_PORT_W-1:0]    s_col,
    input  logic signed [sct_pkg::VALUE_W-1:0] s_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [sct_pkg::VALUE_W-1:0] m_read_value,
    output logic                              m_found,
    output logic [sct_pkg::STATUS_W-1:0]      m_status,
    output logic [sct_pkg::COUNT_PORT_W-1:0]  m_entry_count,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sct_pkg::DIM_W-1:0]         cfg_data,

    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output logic [ENTRY_W-1:0]                mem_wr_data,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_rd_addr,
    input  logic [ENTRY_W-1:0]                mem_rd_data
);

    import sct_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_ACT   = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  swapped_reg, swapped_next;
    logic [DIM_W-1:0]      num_rows_reg, num_cols_reg;

    logic [MODE_W-1:0]     op_mode_reg, op_mode_next;
    logic [INDEX_BITS-1:0] op_row_reg, op_row_next;
    logic [INDEX_BITS-1:0] op_col_reg, op_col_next;
    logic [VALUE_W-1:0]    op_value_reg, op_value_next;

    logic [CNT_W-1:0]      iss_idx_reg, iss_idx_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;

    logic                  hit_reg, hit_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic [VALUE_W-1:0]    hit_val_reg, hit_val_next;

    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic                  res_found_reg, res_found_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;

    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]    m_value_reg, m_value_next;
    logic                  m_found_reg, m_found_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;

    logic [INDEX_BITS-1:0] rd_row, rd_col;
    logic [VALUE_W-1:0]    rd_value;
    logic [VALUE_W-1:0]    prod;
    logic                  match, issue, out_free, in_bounds;
    logic [DIM_W-1:0]      cur_rows, cur_cols;

    assign rd_row   = mem_rd_data[ENTRY_W-1 -: INDEX_BITS];
    assign rd_col   = mem_rd_data[VALUE_W +: INDEX_BITS];
    assign rd_value = mem_rd_data[VALUE_W-1:0];
    assign prod     = rd_value * op_value_reg;

    assign match    = pend_reg && (rd_row == op_row_reg) && (rd_col == op_col_reg);
    assign issue    = iss_idx_reg < count_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign cur_rows  = swapped_reg ? num_cols_reg : num_rows_reg;
    assign cur_cols  = swapped_reg ? num_rows_reg : num_cols_reg;
    assign in_bounds = (DIM_W'(op_row_reg) < cur_rows) && (DIM_W'(op_col_reg) < cur_cols);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_found       = m_found_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = COUNT_PORT_W'(m_count_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        swapped_next    = swapped_reg;
        op_mode_next    = op_mode_reg;
        op_row_next     = op_row_reg;
        op_col_next     = op_col_reg;
        op_value_next   = op_value_reg;
        iss_idx_next    = iss_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        hit_val_next    = hit_val_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_found_next    = m_found_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = pend_idx_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = iss_idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_mode_next    = s_mode;
                    op_row_next     = s_row[INDEX_BITS-1:0];
                    op_col_next     = s_col[INDEX_BITS-1:0];
                    op_value_next   = s_value;
                    iss_idx_next    = '0;
                    pend_next       = 1'b0;
                    res_value_next  = '0;
                    res_found_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    case (mode_t'(s_mode))
                        MODE_SET, MODE_GET, MODE_ADD, MODE_REMOVE: begin
                            state_next = ST_SCAN;
                        end
                        MODE_SCALE, MODE_TRANSPOSE: begin
                            state_next = ST_SWEEP;
                        end
                        default: begin
                            res_status_next = STATUS_BAD_POS;
                            state_next      = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    hit_next     = 1'b1;
                    slot_next    = pend_idx_reg;
                    hit_val_next = rd_value;
                    pend_next    = 1'b0;
                    state_next   = ST_ACT;
                end else if (issue) begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = iss_idx_reg[AW-1:0];
                    iss_idx_next  = iss_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        hit_next   = 1'b0;
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT: begin
                res_found_next = hit_reg;
                state_next     = ST_FIN;
                case (mode_t'(op_mode_reg))
                    MODE_SET, MODE_ADD: begin
                        if (!in_bounds) begin
                            res_status_next = STATUS_BAD_POS;
                        end else if (hit_reg) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = slot_reg;
                            mem_wr_data = {op_row_reg, op_col_reg,
                                           (mode_t'(op_mode_reg) == MODE_SET) ?
                                           op_value_reg : hit_val_reg + op_value_reg};
                        end else if (count_reg >= CAP_CNT) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[AW-1:0];
                            mem_wr_data = {op_row_reg, op_col_reg, op_value_reg};
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    MODE_GET: begin
                        res_value_next = hit_reg ? hit_val_reg : '0;
                    end
                    MODE_REMOVE: begin
                        if (hit_reg) begin
                            iss_idx_next = CNT_W'(slot_reg) + 1'b1;
                            pend_next    = 1'b0;
                            state_next   = ST_SHIFT;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_SHIFT: begin
                // entry i+1 moves down to i, one per cycle
                if (pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg - 1'b1;
                    mem_wr_data = mem_rd_data;
                end
                if (issue) begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = iss_idx_reg[AW-1:0];
                    iss_idx_next  = iss_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SWEEP: begin
                if (pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg;
                    if (mode_t'(op_mode_reg) == MODE_TRANSPOSE) begin
                        mem_wr_data = {rd_col, rd_row, rd_value};
                    end else begin
                        mem_wr_data = {rd_row, rd_col, prod};
                    end
                end
                if (issue) begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = iss_idx_reg[AW-1:0];
                    iss_idx_next  = iss_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (mode_t'(op_mode_reg) == MODE_TRANSPOSE) begin
                            swapped_next = !swapped_reg;
                        end
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_found_next  = res_found_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            swapped_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            num_rows_reg <= DIM_RESET;
            num_cols_reg <= DIM_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            swapped_reg <= swapped_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && (cfg_index == REG_NUM_ROWS)) begin
                num_rows_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_NUM_COLS)) begin
                num_cols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_mode_reg    <= op_mode_next;
        op_row_reg     <= op_row_next;
        op_col_reg     <= op_col_next;
        op_value_reg   <= op_value_next;
        iss_idx_reg    <= iss_idx_next;
        pend_idx_reg   <= pend_idx_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        hit_val_reg    <= hit_val_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_found_reg    <= m_found_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_no_wr_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_FIN) |-> !mem_wr_en)
        else $error("table write outside an operation");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write to the same entry in one cycle");

    a_count_change_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg))) |->
        ($past(state_reg) == ST_ACT || $past(state_reg) == ST_SHIFT))
        else $error("entry count changed outside append or remove");

    a_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACT && hit_reg) |-> (CNT_W'(slot_reg) < count_reg))
        else $error("matched slot beyond stored entries");
`endif

endmodule

FILE: hw/rtl/sparse_coordinate_table_top.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_mode, s_row, s_col, s_value
// m_        out        m_valid / m_ready     m_read_value, m_found, m_status, m_entry_count
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (0 num_rows, 1 num_cols)
//
// One transaction at a time. The single-port-read table is walked one entry per cycle
// through its registered read port, over the N stored entries.
// set/get/add: search, then at most one update. remove: search up to the match,
// then shift down the rest. scale/transpose: one sweep that rewrites every entry.
// Unused modes: no search, straight to the result with a bad-position status.
// Reset clears the count and flags and sets both dimensions to 1; the table has no clearing pass.
// A waiting result does not block acceptance; a finished item waits only for m_ready.
module sparse_coordinate_table_top #(
    parameter int CAPACITY   = sct_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = sct_pkg::DEF_INDEX_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sct_pkg::MODE_W-1:0]         s_mode,
    input  logic [sct_pkg::IDX_PORT_W-1:0]     s_row,
    input  logic [sct_pkg::IDX_PORT_W-1:0]     s_col,
    input  logic signed [sct_pkg::VALUE_W-1:0] s_value,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [sct_pkg::VALUE_W-1:0] m_read_value,
    output logic                               m_found,
    output logic [sct_pkg::STATUS_W-1:0]       m_status,
    output logic [sct_pkg::COUNT_PORT_W-1:0]   m_entry_count,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sct_pkg::DIM_W-1:0]          cfg_data
);

    import sct_pkg::*;

    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENTRY_W = 2 * INDEX_BITS + VALUE_W;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    sct_ctrl #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_found       (m_found),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    sct_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
